// ===== sv/zpmac_pkg.sv =====
package zpmac_pkg;

  // Default sizes of the accumulator store and of the reduction length.
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_DEPTH_DEF   = 65535;

  // Field widths.
  localparam int BYTE_W        = 8;
  localparam int OFFSET_W      = 9;
  localparam int DIFF_W        = 10;
  localparam int SUM_W         = 32;
  localparam int COL_INDEX_W   = 6;
  localparam int COL_COUNT_W   = 7;
  localparam int DEPTH_COUNT_W = 16;

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_A_IS_SIGNED         = 3'd0,
    REG_B_IS_SIGNED         = 3'd1,
    REG_A_OFFSET            = 3'd2,
    REG_B_OFFSET_PER_COLUMN = 3'd3,
    REG_B_OFFSET_SHARED     = 3'd4,
    REG_COLUMN_COUNT        = 3'd5,
    REG_DEPTH_COUNT         = 3'd6
  } cfg_reg_t;

endpackage

// ===== sv/zero_point_vector_matrix_mac_unit.sv =====
// Channel  | Direction | Ports                                  | Contents
// ---------+-----------+----------------------------------------+--------------------------------
// in       | slave     | in_tvalid, in_tready, in_tdata         | a_byte, b_byte, b_column_offset
// out      | master    | out_tvalid, out_tready, out_tdata,     | column_index, column_sum,
//          |           | out_tlast                              | final_column (tlast)
// cfg      | write     | cfg_we, cfg_index, cfg_wdata           | one register per write
//
// An input transfer can be accepted in every cycle unless a finished sum waits behind a stalled
// output; a result passes through the multiply-accumulate stage and then the output
// register. The rate is set by the accumulator store: one read and one write port, with
// the previous item's sum forwarded when two items in a row hit the same column.
// Reset (rst_n low at a clock edge) empties both stages and restores the register defaults;
// the accumulator store is not cleared, since row zero always overwrites an entry first.
// A stalled output holds its result, and the stage behind it keeps flowing as long as the
// item there produces no result.
module zero_point_vector_matrix_mac_unit #(
  parameter int MAX_COLUMNS = zpmac_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_DEPTH   = zpmac_pkg::MAX_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [zpmac_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [zpmac_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: a_byte [7:0], b_byte [15:8], b_column_offset [24:16], zero fill.
  input  logic [zpmac_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: column_index [5:0], column_sum [37:6], zero fill.
  output logic [zpmac_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                out_tlast
);

  localparam int BYTE_W   = zpmac_pkg::BYTE_W;
  localparam int OFFSET_W = zpmac_pkg::OFFSET_W;
  localparam int DIFF_W   = zpmac_pkg::DIFF_W;
  localparam int SUM_W    = zpmac_pkg::SUM_W;
  localparam int CIDX_W   = zpmac_pkg::COL_INDEX_W;
  localparam int CCNT_W   = zpmac_pkg::COL_COUNT_W;
  localparam int DCNT_W   = zpmac_pkg::DEPTH_COUNT_W;
  localparam int PROD_W   = 2 * DIFF_W;

  // Position widths and the widths at which counts are compared.
  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CC_W  = ($clog2(MAX_COLUMNS + 1) > CCNT_W) ? $clog2(MAX_COLUMNS + 1) : CCNT_W;
  localparam int DC_W  = ($clog2(MAX_DEPTH + 1) > DCNT_W) ? $clog2(MAX_DEPTH + 1) : DCNT_W;
  localparam logic [CC_W-1:0] MAX_COLS_C  = CC_W'(MAX_COLUMNS);
  localparam logic [DC_W-1:0] MAX_DEPTH_C = DC_W'(MAX_DEPTH);

  // Configuration registers.
  logic                       a_twos_r;
  logic                       b_twos_r;
  logic signed [OFFSET_W-1:0] a_offset_r;
  logic                       b_per_col_r;
  logic signed [OFFSET_W-1:0] b_offset_r;
  logic [CCNT_W-1:0]          col_count_r;
  logic [DCNT_W-1:0]          depth_count_r;

  // Position of the next item in the product.
  logic [COL_W-1:0] col_pos_r;
  logic [ROW_W-1:0] row_pos_r;
  logic [COL_W-1:0] col_pos_nxt;
  logic [ROW_W-1:0] row_pos_nxt;

  // Multiply-accumulate stage.
  logic                     s1_valid_r;
  logic signed [DIFF_W-1:0] s1_a_r;
  logic signed [DIFF_W-1:0] s1_b_r;
  logic [COL_W-1:0]         s1_col_r;
  logic                     s1_first_r;
  logic                     s1_last_row_r;
  logic                     s1_last_col_r;
  logic [SUM_W-1:0]         rd_r;
  logic                     fwd_r;
  logic [SUM_W-1:0]         fwd_data_r;

  // Output register.
  logic                     out_valid_r;
  logic [CIDX_W-1:0]        out_col_r;
  logic [SUM_W-1:0]         out_sum_r;
  logic                     out_last_r;

  // Accumulator store, one entry per column.
  logic [SUM_W-1:0] acc_mem [MAX_COLUMNS];

  logic in_accept;
  logic s1_adv;
  logic cfg_restart;

  logic [BYTE_W-1:0]   a_byte;
  logic [BYTE_W-1:0]   b_byte;
  logic [OFFSET_W-1:0] b_col_off;

  logic [CC_W-1:0]  cc_ext;
  logic [CC_W-1:0]  eff_cols;
  logic [DC_W-1:0]  dc_ext;
  logic [DC_W-1:0]  eff_depth;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             last_col;
  logic             last_row;

  logic signed [OFFSET_W-1:0] a_val;
  logic signed [OFFSET_W-1:0] b_val;
  logic signed [OFFSET_W-1:0] zb;
  logic signed [DIFF_W-1:0]   a_diff;
  logic signed [DIFF_W-1:0]   b_diff;

  logic signed [PROD_W-1:0] prod;
  logic [SUM_W-1:0]         prod_ext;
  logic [SUM_W-1:0]         acc_in;
  logic [SUM_W-1:0]         s1_sum;
  logic [COL_W+CIDX_W-1:0]  col_wide;

  assign a_byte    = in_tdata[BYTE_W-1:0];
  assign b_byte    = in_tdata[2*BYTE_W-1:BYTE_W];
  assign b_col_off = in_tdata[2*BYTE_W+OFFSET_W-1:2*BYTE_W];

  // The stage behind the output register moves on unless its result has nowhere to go.
  assign s1_adv    = s1_valid_r && (!s1_last_row_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  assign cfg_restart = cfg_we && ((cfg_index == zpmac_pkg::REG_COLUMN_COUNT) ||
                                  (cfg_index == zpmac_pkg::REG_DEPTH_COUNT));

  // Effective geometry: a zero count acts as one, a count beyond the store acts as its size.
  always_comb begin
    cc_ext = CC_W'(col_count_r);
    if (cc_ext == '0) begin
      eff_cols = CC_W'(1);
    end else if (cc_ext > MAX_COLS_C) begin
      eff_cols = MAX_COLS_C;
    end else begin
      eff_cols = cc_ext;
    end
    dc_ext = DC_W'(depth_count_r);
    if (dc_ext == '0) begin
      eff_depth = DC_W'(1);
    end else if (dc_ext > MAX_DEPTH_C) begin
      eff_depth = MAX_DEPTH_C;
    end else begin
      eff_depth = dc_ext;
    end
  end

  // Current position, next position and the last-row and last-column flags.
  always_comb begin
    col_cur  = (CC_W'(col_pos_r) >= eff_cols) ? '0 : col_pos_r;
    row_cur  = (DC_W'(row_pos_r) >= eff_depth) ? '0 : row_pos_r;
    last_col = (CC_W'(col_cur) + CC_W'(1)) >= eff_cols;
    last_row = (DC_W'(row_cur) + DC_W'(1)) >= eff_depth;
    if (last_col) begin
      col_pos_nxt = '0;
      row_pos_nxt = last_row ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_pos_nxt = col_cur + COL_W'(1);
      row_pos_nxt = row_cur;
    end
  end

  // Zero-point subtraction on the incoming bytes.
  always_comb begin
    a_val  = a_twos_r ? OFFSET_W'($signed(a_byte)) : $signed({1'b0, a_byte});
    b_val  = b_twos_r ? OFFSET_W'($signed(b_byte)) : $signed({1'b0, b_byte});
    zb     = b_per_col_r ? $signed(b_col_off) : b_offset_r;
    a_diff = DIFF_W'(a_val) - DIFF_W'(a_offset_r);
    b_diff = DIFF_W'(b_val) - DIFF_W'(zb);
  end

  // Multiply and accumulate. Row zero starts a fresh sum, so the stored entry is ignored
  // there. When the previous item wrote the same column in the cycle this one read the
  // store, its sum is taken from the forwarding register instead.
  always_comb begin
    prod     = s1_a_r * s1_b_r;
    prod_ext = SUM_W'(prod);
    acc_in   = fwd_r ? fwd_data_r : rd_r;
    s1_sum   = s1_first_r ? prod_ext : acc_in + prod_ext;
    col_wide = {{CIDX_W{1'b0}}, s1_col_r};
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_twos_r      <= 1'b0;
      b_twos_r      <= 1'b0;
      a_offset_r    <= '0;
      b_per_col_r   <= 1'b0;
      b_offset_r    <= '0;
      col_count_r   <= CCNT_W'(1);
      depth_count_r <= DCNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        zpmac_pkg::REG_A_IS_SIGNED: begin
          a_twos_r <= cfg_wdata[0];
        end
        zpmac_pkg::REG_B_IS_SIGNED: begin
          b_twos_r <= cfg_wdata[0];
        end
        zpmac_pkg::REG_A_OFFSET: begin
          a_offset_r <= $signed(cfg_wdata[OFFSET_W-1:0]);
        end
        zpmac_pkg::REG_B_OFFSET_PER_COLUMN: begin
          b_per_col_r <= cfg_wdata[0];
        end
        zpmac_pkg::REG_B_OFFSET_SHARED: begin
          b_offset_r <= $signed(cfg_wdata[OFFSET_W-1:0]);
        end
        zpmac_pkg::REG_COLUMN_COUNT: begin
          col_count_r <= cfg_wdata[CCNT_W-1:0];
        end
        zpmac_pkg::REG_DEPTH_COUNT: begin
          depth_count_r <= cfg_wdata[DCNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Product position; a geometry write restarts the product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (cfg_restart) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (in_accept) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_last_row_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage payload, store read and forwarding capture.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_a_r        <= a_diff;
      s1_b_r        <= b_diff;
      s1_col_r      <= col_cur;
      s1_first_r    <= (row_cur == '0);
      s1_last_row_r <= last_row;
      s1_last_col_r <= last_col;
      rd_r          <= acc_mem[col_cur];
      fwd_r         <= s1_adv && (s1_col_r == col_cur);
      fwd_data_r    <= s1_sum;
    end
  end

  // Store write as each item leaves the accumulate stage.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      acc_mem[s1_col_r] <= s1_sum;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_row_r) begin
      out_col_r  <= col_wide[CIDX_W-1:0];
      out_sum_r  <= s1_sum;
      out_last_r <= s1_last_col_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(zpmac_pkg::OUT_TDATA_W - SUM_W - CIDX_W){1'b0}}, out_sum_r, out_col_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/zpmac_checker.sv =====
module zpmac_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [zpmac_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tlast
);

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A result only appears after the input transfer that caused it.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input transfer");

  // When the output side takes data, the input side is never held off.
  assert property (@(posedge clk) disable iff (!rst_n) out_tready |-> in_tready)
    else $error("input stalled while output is ready");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind zero_point_vector_matrix_mac_unit zpmac_checker u_zpmac_checker (.*);

// ===== verif/zpmac_tb_pkg.sv =====
`timescale 1ns / 100ps

package zpmac_tb_pkg;
  import zpmac_pkg::*;

  typedef struct {
    logic [COL_INDEX_W-1:0] column;
    logic [SUM_W-1:0]       total;
    logic                   last;
  } column_result_t;

  // Tracks the row product as the block should compute it and keeps the
  // finished column sums that have not come out yet.
  class column_sum_tracker;
    bit                          a_twos;
    bit                          b_twos;
    bit                          per_column_zp;
    logic signed [OFFSET_W-1:0]  a_zp;
    logic signed [OFFSET_W-1:0]  b_zp_shared;
    logic [COL_COUNT_W-1:0]      col_count;
    logic [DEPTH_COUNT_W-1:0]    depth_count;
    logic [SUM_W-1:0]            sums [MAX_COLUMNS_DEF];
    int unsigned                 col_pos;
    int unsigned                 row_pos;
    column_result_t              expected_sums [$];
    int unsigned                 failures;

    function new();
      a_twos        = 1'b0;
      b_twos        = 1'b0;
      per_column_zp = 1'b0;
      a_zp          = '0;
      b_zp_shared   = '0;
      col_count     = COL_COUNT_W'(1);
      depth_count   = DEPTH_COUNT_W'(1);
      col_pos       = 0;
      row_pos       = 0;
      failures      = 0;
      foreach (sums[i]) sums[i] = '0;
    endfunction

    function int unsigned columns_in_use();
      if (col_count == 0) return 1;
      if (col_count > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
      return col_count;
    endfunction

    function int unsigned depth_in_use();
      if (depth_count == 0) return 1;
      if (depth_count > MAX_DEPTH_DEF) return MAX_DEPTH_DEF;
      return depth_count;
    endfunction

    function int unsigned product_items();
      return columns_in_use() * depth_in_use();
    endfunction

    function int unsigned pending();
      return expected_sums.size();
    endfunction

    function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_A_IS_SIGNED:         a_twos = value[0];
        REG_B_IS_SIGNED:         b_twos = value[0];
        REG_A_OFFSET:            a_zp = value[OFFSET_W-1:0];
        REG_B_OFFSET_PER_COLUMN: per_column_zp = value[0];
        REG_B_OFFSET_SHARED:     b_zp_shared = value[OFFSET_W-1:0];
        REG_COLUMN_COUNT: begin
          col_count = value[COL_COUNT_W-1:0];
          col_pos   = 0;
          row_pos   = 0;
        end
        REG_DEPTH_COUNT: begin
          depth_count = value[DEPTH_COUNT_W-1:0];
          col_pos     = 0;
          row_pos     = 0;
        end
        default: ;
      endcase
    endfunction

    function void take_item(input logic [IN_TDATA_W-1:0] word);
      int unsigned    cols;
      int unsigned    depth;
      int unsigned    col;
      int unsigned    row;
      int             a_val;
      int             b_val;
      int             zp;
      logic [SUM_W-1:0] prod;
      column_result_t r;
      bit             last_row;
      bit             last_col;
      cols  = columns_in_use();
      depth = depth_in_use();
      col   = (col_pos >= cols) ? 0 : col_pos;
      row   = (row_pos >= depth) ? 0 : row_pos;
      if (a_twos) a_val = int'($signed(word[BYTE_W-1:0]));
      else a_val = int'(word[BYTE_W-1:0]);
      if (b_twos) b_val = int'($signed(word[2*BYTE_W-1:BYTE_W]));
      else b_val = int'(word[2*BYTE_W-1:BYTE_W]);
      if (per_column_zp) zp = int'($signed(word[2*BYTE_W+OFFSET_W-1:2*BYTE_W]));
      else zp = int'(b_zp_shared);
      a_val = a_val - int'(a_zp);
      b_val = b_val - zp;
      prod  = a_val * b_val;
      if (row == 0) sums[col] = prod;
      else sums[col] = sums[col] + prod;
      last_row = (row + 1 >= depth);
      last_col = (col + 1 >= cols);
      if (last_row) begin
        r.column = col[COL_INDEX_W-1:0];
        r.total  = sums[col];
        r.last   = last_col;
        expected_sums.push_back(r);
      end
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : row + 1;
      end else begin
        col_pos = col + 1;
        row_pos = row;
      end
    endfunction

    function void check_sum(input logic [OUT_TDATA_W-1:0] word, input logic tlast);
      column_result_t         want;
      logic [COL_INDEX_W-1:0] got_col;
      logic [SUM_W-1:0]       got_sum;
      got_col = word[COL_INDEX_W-1:0];
      got_sum = word[COL_INDEX_W+SUM_W-1:COL_INDEX_W];
      if (expected_sums.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected sum: col %0d sum %0d final %0b",
                   got_col, $signed(got_sum), tlast);
        return;
      end
      want = expected_sums.pop_front();
      if (got_col !== want.column || got_sum !== want.total || tlast !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("sum mismatch: col exp %0d got %0d, sum exp %0d got %0d, final exp %0b got %0b",
                   want.column, got_col, $signed(want.total), $signed(got_sum),
                   want.last, tlast);
      end
    endfunction

    function void flush_leftovers();
      if (expected_sums.size() != 0) begin
        failures += expected_sums.size();
        $display("%0d column sums never came out", expected_sums.size());
        expected_sums.delete();
      end
    endfunction
  endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import zpmac_pkg::*;
  import zpmac_tb_pkg::*;

  // Index 7 has no register behind it; a write there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNASSIGNED = 3'd7;

  localparam int RANDOM_ITEMS  = 1430;
  localparam int HOLD_CYCLES   = 300;
  // Results pass through the accumulate stage and the output register; this margin
  // covers items still in flight that produce no result.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  column_sum_tracker sums_book;

  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  int          burst_left = 0;
  bit          gapless    = 1'b0;
  bit          hold_req   = 1'b0;

  zero_point_vector_matrix_mac_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // All inputs change through nonblocking assignments at the rising edge, so
  // this block always sees the values that were present at the edge. Register
  // writes, accepted items and accepted results are handled in that order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sums_book.write_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) sums_book.take_item(in_tdata);
      if (out_tvalid && out_tready) sums_book.check_sum(out_tdata, out_tlast);
    end
  end

  // Hard stop in case the block hangs or loses a transfer.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver changes its stall behavior after each random span: always
  // ready, mostly ready, mostly stalled, or ready on a fixed period. When the
  // stimulus asks for it, it stalls for a long stretch so the block backs up.
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    int       period;
    int       k;
    out_tready <= 1'b0;
    forever begin
      mode   = rx_mode_t'($urandom_range(0, 3));
      span   = $urandom_range(20, 200);
      period = $urandom_range(2, 5);
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end else begin
          case (mode)
            RX_OPEN:     out_tready <= 1'b1;
            RX_MOSTLY:   out_tready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE:   out_tready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: out_tready <= (k % period == 0);
            default:     out_tready <= 1'b1;
          endcase
        end
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] item_word(input logic [BYTE_W-1:0] a,
                                                      input logic [BYTE_W-1:0] b,
                                                      input logic [OFFSET_W-1:0] zp);
    return {{(IN_TDATA_W-2*BYTE_W-OFFSET_W){1'b0}}, zp, b, a};
  endfunction

  // Bytes lean toward the sign and range boundaries.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Zero points: -128 and 255, zero, -256 and -1, and any 9-bit pattern.
  function automatic logic [OFFSET_W-1:0] pick_offset();
    case ($urandom_range(0, 7))
      0: return 9'h180;
      1: return 9'h0FF;
      2: return 9'h000;
      3: return 9'h100;
      4: return 9'h1FF;
      default: return OFFSET_W'($urandom_range(0, 511));
    endcase
  endfunction

  // One register write; the enable is high for exactly one edge.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one item and returns at the edge where the transfer happens. Items go
  // out in bursts of random length; a random gap may open before each burst.
  task automatic send_item(input logic [IN_TDATA_W-1:0] word);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (!gapless && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stops offering items and waits until every expected sum has come out, then
  // lets the pipeline settle so a register write cannot hit an item in flight.
  task automatic wait_idle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sums_book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned        random_start;
    int unsigned        n;
    int unsigned        count;
    logic [CFG_DATA_W-1:0] wd;
    logic [COL_COUNT_W-1:0] cols;
    logic [DEPTH_COUNT_W-1:0] depth;

    sums_book = new();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: unsigned bytes, zero offsets, one column, depth one, so
    // every item is a finished product. The column zero point is ignored here.
    send_item(item_word(8'hFF, 8'hFF, 9'h1FF));
    send_item(item_word(8'h00, 8'h00, 9'h0AA));
    wait_idle();

    // Signed bytes against the zero points -128 and 255.
    // The write to the unassigned index must leave everything as it was.
    cfg_write(REG_A_IS_SIGNED, 16'd1);
    cfg_write(REG_B_IS_SIGNED, 16'd1);
    cfg_write(REG_A_OFFSET, 16'h0180);
    cfg_write(REG_B_OFFSET_SHARED, 16'h00FF);
    cfg_write(REG_UNASSIGNED, 16'hFFFF);
    send_item(item_word(8'h80, 8'h7F, 9'h000));
    send_item(item_word(8'h7F, 8'h80, 9'h100));
    send_item(item_word(8'hFF, 8'h00, 9'h1FF));
    wait_idle();

    // Per-column zero points on a three by two product with unsigned bytes.
    cfg_write(REG_A_IS_SIGNED, 16'd0);
    cfg_write(REG_B_IS_SIGNED, 16'd0);
    cfg_write(REG_A_OFFSET, 16'h00FF);
    cfg_write(REG_B_OFFSET_PER_COLUMN, 16'd1);
    cfg_write(REG_COLUMN_COUNT, 16'd3);
    cfg_write(REG_DEPTH_COUNT, 16'd2);
    send_item(item_word(8'h00, 8'hFF, 9'h180));
    send_item(item_word(8'h00, 8'h00, 9'h0FF));
    send_item(item_word(8'h00, 8'h80, 9'h100));
    send_item(item_word(8'hFF, 8'hFF, 9'h180));
    send_item(item_word(8'hFF, 8'h00, 9'h0FF));
    send_item(item_word(8'hFF, 8'h7F, 9'h1FF));
    wait_idle();

    // Zero column and depth counts behave as one. The upper data bits of the
    // column write fall outside the register.
    cfg_write(REG_COLUMN_COUNT, 16'hFF80);
    cfg_write(REG_DEPTH_COUNT, 16'd0);
    send_item(item_word(8'h12, 8'h34, 9'h0C5));
    send_item(item_word(8'hFE, 8'h01, 9'h13A));
    wait_idle();

    // A geometry write in the middle of a product starts it over: four items of
    // a two by three product are dropped, then a full product follows.
    cfg_write(REG_COLUMN_COUNT, 16'd2);
    cfg_write(REG_DEPTH_COUNT, 16'd3);
    repeat (4) send_item(item_word(pick_byte(), pick_byte(), pick_offset()));
    wait_idle();
    cfg_write(REG_DEPTH_COUNT, 16'd3);
    repeat (6) send_item(item_word(pick_byte(), pick_byte(), pick_offset()));
    wait_idle();

    // The deepest reduction the depth register allows, on a single column. Only
    // its first rows are sent, so no sum may come out; the next geometry write
    // starts over. A full reduction of a hundred rows follows.
    cfg_write(REG_COLUMN_COUNT, 16'd1);
    cfg_write(REG_DEPTH_COUNT, 16'hFFFF);
    gapless = 1'b1;
    repeat (120) send_item(item_word(pick_byte(), pick_byte(), pick_offset()));
    wait_idle();
    cfg_write(REG_DEPTH_COUNT, 16'd100);
    repeat (100) send_item(item_word(pick_byte(), pick_byte(), pick_offset()));
    wait_idle();

    // Every item yields a sum while the receiver holds off for a long stretch,
    // so the output backs up and the block must stall its input.
    cfg_write(REG_COLUMN_COUNT, 16'd4);
    cfg_write(REG_DEPTH_COUNT, 16'd1);
    hold_req = 1'b1;
    repeat (80) send_item(item_word(pick_byte(), pick_byte(), pick_offset()));
    wait_idle();
    gapless = 1'b0;

    // Random phases. Each one usually sets a new geometry and some of the modes
    // and offsets, then runs whole products with random bytes, sometimes with a
    // partial product left over. A phase that keeps the geometry resumes that
    // leftover under the new modes. Most geometries are small; a few use all
    // 64 columns or a count beyond it.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (items_sent == random_start || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 15))
          0: cols = COL_COUNT_W'(0);
          1: cols = COL_COUNT_W'(64);
          2: cols = COL_COUNT_W'($urandom_range(65, 127));
          default: cols = COL_COUNT_W'($urandom_range(1, 8));
        endcase
        if (cols > 8 || cols == 0) depth = DEPTH_COUNT_W'($urandom_range(0, 2));
        else begin
          case ($urandom_range(0, 9))
            0: depth = DEPTH_COUNT_W'(0);
            1: depth = DEPTH_COUNT_W'($urandom_range(10, 24));
            default: depth = DEPTH_COUNT_W'($urandom_range(1, 5));
          endcase
        end
        if ($urandom_range(0, 3) != 0) begin
          wd = CFG_DATA_W'($urandom);
          wd[COL_COUNT_W-1:0] = cols;
          cfg_write(REG_COLUMN_COUNT, wd);
        end
        cfg_write(REG_DEPTH_COUNT, depth);
      end
      if ($urandom_range(0, 1)) cfg_write(REG_A_IS_SIGNED, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) cfg_write(REG_B_IS_SIGNED, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) cfg_write(REG_B_OFFSET_PER_COLUMN, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 1)) begin
        wd = CFG_DATA_W'($urandom);
        wd[OFFSET_W-1:0] = pick_offset();
        cfg_write(REG_A_OFFSET, wd);
      end
      if ($urandom_range(0, 1)) begin
        wd = CFG_DATA_W'($urandom);
        wd[OFFSET_W-1:0] = pick_offset();
        cfg_write(REG_B_OFFSET_SHARED, wd);
      end

      n = sums_book.product_items();
      count = (n > 64) ? n : n * $urandom_range(1, 4);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, n);
      repeat (count) send_item(item_word(pick_byte(), pick_byte(),
                                         OFFSET_W'($urandom_range(0, 511))));
      wait_idle();
    end

    sums_book.flush_leftovers();
    if (sums_book.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/zpmac_pkg.sv
sv/zero_point_vector_matrix_mac_unit.sv
sv/zpmac_checker.sv
verif/zpmac_tb_pkg.sv
verif/tb.sv
